@@ rtl/core/serial_line_editor_core_assert.svh @@
// Assertion macros for serial_line_editor_core.
`ifndef SERIAL_LINE_EDITOR_CORE_ASSERT_SVH
`define SERIAL_LINE_EDITOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define SLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("serial_line_editor_core: assertion failed");
// Next-cycle implication, checked out of reset.
`define SLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("serial_line_editor_core: assertion failed");
`else
`define SLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/sle_pkg.sv @@
`timescale 1ns / 1ps
package sle_pkg;

    localparam int LINE_CAP = 64;
    localparam int LEN_W    = $clog2(LINE_CAP);
    localparam logic [LEN_W-1:0] LINE_LIMIT = LEN_W'(LINE_CAP - 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] KEY_BS  = 8'd8;
    localparam logic [7:0] KEY_DEL = 8'd127;
    localparam logic [7:0] KEY_CR  = 8'd13;
    localparam logic [7:0] KEY_LF  = 8'd10;

    typedef enum logic [2:0] {
        ACT_ECHO       = 3'd0,
        ACT_BELL       = 3'd1,
        ACT_BELL_HIDE  = 3'd2,
        ACT_ERASE_SHOW = 3'd3,
        ACT_LINE_BYTE  = 3'd4,
        ACT_LINE_DONE  = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        CMD_CHAR,
        CMD_ERASE,
        CMD_TERM
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] rx_byte;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_EMIT,
        BK_DONE
    } t_bk_state;

endpackage

@@ rtl/core/sle_ram.sv @@
`timescale 1ns / 1ps
module sle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/sle_front.sv @@
`timescale 1ns / 1ps
module sle_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [7:0]    i_rx_byte,
    input  logic          i_q_full,
    output logic          o_cmd_valid,
    output sle_pkg::t_cmd o_cmd
);
    import sle_pkg::*;

    logic  r_valid;
    t_cmd  r_cmd;
    t_cmd  n_cmd;
    logic  load;

    always_comb begin
        n_cmd.rx_byte = i_rx_byte;
        case (i_rx_byte) inside
            KEY_CR, KEY_LF:  n_cmd.kind = CMD_TERM;
            KEY_BS, KEY_DEL: n_cmd.kind = CMD_ERASE;
            default:         n_cmd.kind = CMD_CHAR;
        endcase
    end

    assign load    = !r_valid || !i_q_full;
    assign o_stall = r_valid && i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
        if (load && i_valid) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;
endmodule

@@ rtl/core/sle_queue.sv @@
`timescale 1ns / 1ps
module sle_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sle_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output sle_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import sle_pkg::*;

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_cmd   = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (do_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end
endmodule

@@ rtl/core/sle_back.sv @@
`timescale 1ns / 1ps
module sle_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  sle_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [2:0]    o_action,
    output logic [7:0]    o_data,
    output logic          o_last
);
    import sle_pkg::*;

    t_bk_state        r_state, n_state;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_idx, n_idx;
    logic             r_warned, n_warned;
    logic             r_out_valid, n_out_valid;
    t_action          r_action, n_action;
    logic [7:0]       r_data, n_data;
    logic             r_last, n_last;
    logic             out_free;
    logic             ram_we;
    logic [7:0]       ram_rdata;

    sle_ram #(
        .WIDTH (8),
        .DEPTH (LINE_CAP)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_len),
        .i_wdata (i_cmd.rx_byte),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_len       <= '0;
            r_idx       <= '0;
            r_warned    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_idx       <= n_idx;
            r_warned    <= n_warned;
            r_out_valid <= n_out_valid;
        end
        r_action <= n_action;
        r_data   <= n_data;
        r_last   <= n_last;
    end

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_idx       = r_idx;
        n_warned    = r_warned;
        n_out_valid = r_out_valid && i_stall;
        n_action    = r_action;
        n_data      = r_data;
        n_last      = r_last;
        o_pop       = 1'b0;
        ram_we      = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_pop = 1'b1;
                    case (i_cmd.kind)
                        CMD_CHAR: begin
                            n_out_valid = 1'b1;
                            n_last      = 1'b1;
                            n_data      = 8'd0;
                            if (r_len < LINE_LIMIT) begin
                                ram_we   = 1'b1;
                                n_len    = r_len + 1'b1;
                                n_action = ACT_ECHO;
                                n_data   = i_cmd.rx_byte;
                            end else if (!r_warned) begin
                                n_warned = 1'b1;
                                n_action = ACT_BELL_HIDE;
                            end else begin
                                n_action = ACT_BELL;
                            end
                        end
                        CMD_ERASE: begin
                            if (r_len != '0) begin
                                n_len       = r_len - 1'b1;
                                n_warned    = 1'b0;
                                n_out_valid = 1'b1;
                                n_action    = ACT_ERASE_SHOW;
                                n_data      = 8'd0;
                                n_last      = 1'b1;
                            end
                        end
                        CMD_TERM: begin
                            if (r_len == '0) begin
                                n_warned    = 1'b0;
                                n_out_valid = 1'b1;
                                n_action    = ACT_LINE_DONE;
                                n_data      = 8'd0;
                                n_last      = 1'b1;
                            end else begin
                                n_idx   = '0;
                                n_state = BK_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BK_READ: begin
                n_state = BK_EMIT;
            end
            BK_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_action    = ACT_LINE_BYTE;
                    n_data      = ram_rdata;
                    n_last      = 1'b0;
                    if (r_idx == r_len - 1'b1) begin
                        n_state = BK_DONE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = BK_READ;
                    end
                end
            end
            BK_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_action    = ACT_LINE_DONE;
                    n_data      = 8'd0;
                    n_last      = 1'b1;
                    n_len       = '0;
                    n_warned    = 1'b0;
                    n_state     = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    assign o_valid  = r_out_valid;
    assign o_action = r_action;
    assign o_data   = r_data;
    assign o_last   = r_last;
endmodule

@@ rtl/core/serial_line_editor_core.sv @@
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// input     i_valid / o_stall    i_rx_byte[7:0]
// output    o_valid / i_stall    o_action[2:0], o_data[7:0], o_last
//
// Edit bytes: front register, then queue slot, then output register.
// Terminator: the back end pops it, then per stored byte does a line RAM read and
// an output load, then loads line done.
// Reset: synchronous on i_rst_n low; line length, flag, queue and valids cleared.
// A stalled output holds the back end; the front register and 2-entry queue keep
// accepting until full.
module serial_line_editor_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_action,
    output logic [7:0] o_data,
    output logic       o_last
);
    import sle_pkg::*;
`include "serial_line_editor_core_assert.svh"

    logic fr_valid;
    t_cmd fr_cmd;
    logic q_full;
    logic q_valid;
    t_cmd q_cmd;
    logic bk_pop;
    logic is_line_byte;
    logic has_data;

    sle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_rx_byte   (i_rx_byte),
        .i_q_full    (q_full),
        .o_cmd_valid (fr_valid),
        .o_cmd       (fr_cmd)
    );

    sle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_valid),
        .i_cmd   (fr_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (bk_pop)
    );

    sle_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (bk_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_action    (o_action),
        .o_data      (o_data),
        .o_last      (o_last)
    );

    assign is_line_byte = (o_action == ACT_LINE_BYTE);
    assign has_data     = (o_action == ACT_ECHO) || is_line_byte;

    `SLE_ASSERT_IMP(a_last_marks_end, i_clk, i_rst_n, o_valid, o_last == !is_line_byte)
    `SLE_ASSERT_IMP(a_data_zero, i_clk, i_rst_n, o_valid && !has_data, o_data == 8'd0)
    `SLE_ASSERT_NXT(a_accept_lands, i_clk, i_rst_n, i_valid && !o_stall, fr_valid)
    `SLE_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, bk_pop, q_valid)
endmodule

@@ tb/sv/serial_line_editor_core_tb.sv @@
`timescale 1ns / 1ps
module serial_line_editor_core_tb;
    import sle_pkg::*;

    localparam int unsigned RUN_LIMIT  = 300000;
    localparam int unsigned HOLD_LEN   = 400;
    localparam int unsigned DRAIN_WAIT = 2 * LINE_CAP + 16;
    localparam int unsigned LINE_MAX   = LINE_CAP - 1;

    typedef struct {
        t_action    action;
        logic [7:0] data;
        logic       last;
    } line_result_t;

    typedef enum {
        RX_FREE,
        RX_RANDOM,
        RX_PERIODIC
    } rx_pattern_t;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_stall   = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [2:0] o_action;
    logic [7:0] o_data;
    logic       o_last;

    // predictor state
    logic [7:0]  line_buf [LINE_CAP];
    int unsigned line_len  = 0;
    bit          warned    = 1'b0;
    line_result_t pending_results[$];

    int unsigned cycle_count = 0;
    int unsigned mismatches  = 0;
    int unsigned burst_left  = 0;
    bit          gaps_on     = 1'b1;
    bit          hold_req    = 1'b0;
    int unsigned hold_left   = 0;
    rx_pattern_t rx_pattern  = RX_FREE;

    serial_line_editor_core i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_rx_byte(i_rx_byte),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_action (o_action),
        .o_data   (o_data),
        .o_last   (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic void push_result(input t_action act, input logic [7:0] dat,
                                        input logic lst);
        line_result_t r;
        r.action = act;
        r.data   = dat;
        r.last   = lst;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_edit(input logic [7:0] rx);
        if (rx == KEY_CR || rx == KEY_LF) begin
            for (int i = 0; i < line_len; i++)
                push_result(ACT_LINE_BYTE, line_buf[i], 1'b0);
            push_result(ACT_LINE_DONE, 8'h00, 1'b1);
            line_len = 0;
            warned   = 1'b0;
        end else if (rx == KEY_BS || rx == KEY_DEL) begin
            if (line_len > 0) begin
                line_len--;
                warned = 1'b0;
                push_result(ACT_ERASE_SHOW, 8'h00, 1'b1);
            end
        end else if (line_len < LINE_MAX) begin
            line_buf[line_len] = rx;
            line_len++;
            push_result(ACT_ECHO, rx, 1'b1);
        end else if (!warned) begin
            warned = 1'b1;
            push_result(ACT_BELL_HIDE, 8'h00, 1'b1);
        end else begin
            push_result(ACT_BELL, 8'h00, 1'b1);
        end
    endfunction

    function automatic logic [7:0] ordinary_byte();
        logic [7:0] b;
        b = 8'($urandom);
        while (b == KEY_BS || b == KEY_DEL || b == KEY_CR || b == KEY_LF)
            b = 8'($urandom);
        return b;
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch @%0t: %s", $realtime, msg);
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_byte(input logic [7:0] rx);
        i_valid   <= 1'b1;
        i_rx_byte <= rx;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        predict_edit(rx);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            if (gaps_on && $urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
            end
        end
    endtask

    // receiver stall pattern, with an optional long hold-off
    always @(negedge i_clk) begin
        logic stall_next;
        if (hold_req) begin
            hold_left = HOLD_LEN;
            hold_req  = 1'b0;
        end
        if ($urandom_range(0, 149) == 0)
            rx_pattern = rx_pattern_t'($urandom_range(0, 2));
        if (hold_left > 0) begin
            stall_next = 1'b1;
            hold_left--;
        end else begin
            case (rx_pattern)
                RX_FREE:   stall_next = 1'b0;
                RX_RANDOM: stall_next = ($urandom_range(0, 3) == 0);
                default:   stall_next = ((cycle_count % 7) < 3);
            endcase
        end
        i_stall <= stall_next;
    end

    // result checker
    always @(posedge i_clk) begin
        line_result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("unexpected transfer action=%0d data=%02h last=%0b",
                                        o_action, o_data, o_last));
            end else begin
                want = pending_results.pop_front();
                if (o_action !== want.action || o_data !== want.data || o_last !== want.last)
                    note_mismatch($sformatf(
                        "exp action=%0d data=%02h last=%0b, got action=%0d data=%02h last=%0b",
                        want.action, want.data, want.last, o_action, o_data, o_last));
            end
        end
    end

    task automatic test_edit_basics();
        send_byte(KEY_BS);
        send_byte(KEY_LF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(8'h07);
        send_byte(8'h09);
        send_byte(KEY_DEL);
        send_byte(KEY_BS);
        send_byte(8'h7E);
        send_byte(8'h80);
        send_byte(KEY_CR);
        send_byte(KEY_DEL);
        send_byte(8'h01);
        send_byte(KEY_CR);
    endtask

    // full line, overflow bells under a long receiver hold-off while input keeps coming
    task automatic test_overflow_backpressure();
        repeat (LINE_MAX) send_byte(ordinary_byte());
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        send_byte(ordinary_byte());
        send_byte(ordinary_byte());
        send_byte(ordinary_byte());
        send_byte(KEY_BS);
        send_byte(ordinary_byte());
        send_byte(ordinary_byte());
        send_byte(KEY_DEL);
        send_byte(KEY_DEL);
        send_byte(KEY_CR);
        repeat (6) send_byte(ordinary_byte());
        send_byte(KEY_LF);
        gaps_on = 1'b1;
    endtask

    task automatic test_random_lines(input int unsigned budget);
        int unsigned sent;
        int unsigned target;
        logic [7:0]  b;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(0, 4) == 0)
                target = LINE_MAX + $urandom_range(1, 6);
            else
                target = $urandom_range(0, 12);
            if (target > budget - sent)
                target = budget - sent;
            repeat (target) begin
                if ($urandom_range(0, 99) < 8)
                    b = $urandom_range(0, 1) ? KEY_BS : KEY_DEL;
                else
                    b = ordinary_byte();
                if (!((b == KEY_BS || b == KEY_DEL) && line_len == 0))
                    sent++;
                send_byte(b);
            end
            if ($urandom_range(0, 9) != 0) begin
                send_byte($urandom_range(0, 1) ? KEY_CR : KEY_LF);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_edit_basics();
        test_overflow_backpressure();
        test_random_lines(75);

        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
